[src/icf_pkg.sv]
// ============================================================================
// icf_pkg - shared types and constants for the constant-fold ALU
// Operation and condition codes, operand widths and the structs that
// travel between the pipeline stages.
// ============================================================================
package icf_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned ACTION_W = 5;
    localparam int unsigned COND_W   = 4;
    localparam int unsigned SHIFT_W  = 6;

    // input word layout, lowest bit up
    localparam int unsigned IN_ACTION_LSB = 0;
    localparam int unsigned IN_WIDE_LSB   = IN_ACTION_LSB + ACTION_W;
    localparam int unsigned IN_X_LSB      = IN_WIDE_LSB + 1;
    localparam int unsigned IN_Y_LSB      = IN_X_LSB + DATA_W;
    localparam int unsigned IN_COND_LSB   = IN_Y_LSB + DATA_W;
    localparam int unsigned IN_USED_W     = IN_COND_LSB + COND_W;
    localparam int unsigned IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] MASK_LO = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 5'd0,
        ACT_SUB    = 5'd1,
        ACT_MUL    = 5'd2,
        ACT_AND    = 5'd3,
        ACT_OR     = 5'd4,
        ACT_XOR    = 5'd5,
        ACT_SHL    = 5'd6,
        ACT_SHR    = 5'd7,
        ACT_SAR    = 5'd8,
        ACT_ROTR   = 5'd9,
        ACT_ROTL   = 5'd10,
        ACT_NOT    = 5'd11,
        ACT_NEG    = 5'd12,
        ACT_ANDC   = 5'd13,
        ACT_ORC    = 5'd14,
        ACT_EQV    = 5'd15,
        ACT_NAND   = 5'd16,
        ACT_NOR    = 5'd17,
        ACT_EXT8S  = 5'd18,
        ACT_EXT16S = 5'd19,
        ACT_EXT8U  = 5'd20,
        ACT_EXT16U = 5'd21,
        ACT_EXT32S = 5'd22,
        ACT_EXT32U = 5'd23,
        ACT_CMP    = 5'd24
    } t_action;

    typedef enum logic [COND_W-1:0] {
        CND_EQ  = 4'd0,
        CND_NE  = 4'd1,
        CND_LT  = 4'd2,
        CND_GE  = 4'd3,
        CND_LE  = 4'd4,
        CND_GT  = 4'd5,
        CND_LTU = 4'd6,
        CND_GEU = 4'd7,
        CND_LEU = 4'd8,
        CND_GTU = 4'd9
    } t_cond;

    // decoded word: operands already cut to the operation width
    typedef struct packed {
        t_action           action;
        logic              wide;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        t_cond             cond;
    } t_dec;

    // executed word: logic result plus multiplier partial products
    typedef struct packed {
        logic              wide;
        logic              is_mul;
        logic [DATA_W-1:0] alu;
        logic [DATA_W-1:0] p_ll;
        logic [HALF_W-1:0] p_lh;
        logic [HALF_W-1:0] p_hl;
    } t_exe;

endpackage

[src/icf_decode.sv]
// ============================================================================
// icf_decode - input stage
// Unpacks the input word, cuts the operands to the operation width and
// registers the decoded word.
// ============================================================================
module icf_decode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [icf_pkg::IN_TDATA_W-1:0]   i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output icf_pkg::t_dec                    o_dec
);
    import icf_pkg::*;

    logic  r_valid;
    t_dec  r_dec;
    t_dec  n_dec;
    logic  w_load;
    logic  [DATA_W-1:0] w_mask;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_dec   = r_dec;

    // field unpack and width mask
    always_comb begin
        n_dec.action = t_action'(i_data[IN_ACTION_LSB +: ACTION_W]);
        n_dec.wide   = i_data[IN_WIDE_LSB];
        w_mask       = n_dec.wide ? {DATA_W{1'b1}} : MASK_LO;
        n_dec.x      = i_data[IN_X_LSB +: DATA_W] & w_mask;
        n_dec.y      = i_data[IN_Y_LSB +: DATA_W] & w_mask;
        n_dec.cond   = t_cond'(i_data[IN_COND_LSB +: COND_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
        if (w_load && i_valid) begin
            r_dec <= n_dec;
        end
    end

endmodule

[src/icf_exec.sv]
// ============================================================================
// icf_exec - execute stage
// Logic, add, shift, rotate, extend and compare in one stage; the 64-bit
// multiply is split into three 32x32 partial products registered here.
// ============================================================================
module icf_exec (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  icf_pkg::t_dec  i_dec,
    output logic           o_valid,
    input  logic           i_ready,
    output icf_pkg::t_exe  o_exe
);
    import icf_pkg::*;

    logic  r_valid;
    t_exe  r_exe;
    t_exe  n_exe;
    logic  w_load;

    logic [SHIFT_W-1:0]   w_sh;
    logic [DATA_W-1:0]    w_x;
    logic [DATA_W-1:0]    w_y;
    logic [DATA_W-1:0]    w_sx;
    logic [DATA_W-1:0]    w_flip;
    logic [2*DATA_W-1:0]  w_rr64;
    logic [2*DATA_W-1:0]  w_rl64;
    logic [DATA_W-1:0]    w_rr32;
    logic [DATA_W-1:0]    w_rl32;
    logic [DATA_W-1:0]    w_m_lh;
    logic [DATA_W-1:0]    w_m_hl;
    logic                 w_ltu;
    logic                 w_lts;
    logic                 w_eq;
    logic                 w_cmp;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_exe   = r_exe;

    assign w_x = i_dec.x;
    assign w_y = i_dec.y;

    // shift count: low 5 or 6 bits
    assign w_sh = i_dec.wide ? w_y[SHIFT_W-1:0] : {1'b0, w_y[SHIFT_W-2:0]};

    // operand sign-extended from the operation width, for sar
    assign w_sx = i_dec.wide ? w_x : {{HALF_W{w_x[HALF_W-1]}}, w_x[HALF_W-1:0]};

    // rotates through a doubled operand
    assign w_rr64 = {w_x, w_x} >> w_sh;
    assign w_rl64 = {w_x, w_x} << w_sh;
    assign w_rr32 = {w_x[HALF_W-1:0], w_x[HALF_W-1:0]} >> w_sh[SHIFT_W-2:0];
    assign w_rl32 = {w_x[HALF_W-1:0], w_x[HALF_W-1:0]} << w_sh[SHIFT_W-2:0];

    // compare: signed order by flipping the width's sign bit
    assign w_flip = i_dec.wide ? {1'b1, {(DATA_W-1){1'b0}}}
                               : {{HALF_W{1'b0}}, 1'b1, {(HALF_W-1){1'b0}}};
    assign w_eq   = (w_x == w_y);
    assign w_ltu  = (w_x < w_y);
    assign w_lts  = ((w_x ^ w_flip) < (w_y ^ w_flip));

    always_comb begin
        unique case (i_dec.cond)
            CND_EQ:  w_cmp = w_eq;
            CND_NE:  w_cmp = !w_eq;
            CND_LT:  w_cmp = w_lts;
            CND_GE:  w_cmp = !w_lts;
            CND_LE:  w_cmp = w_lts || w_eq;
            CND_GT:  w_cmp = !(w_lts || w_eq);
            CND_LTU: w_cmp = w_ltu;
            CND_GEU: w_cmp = !w_ltu;
            CND_LEU: w_cmp = w_ltu || w_eq;
            CND_GTU: w_cmp = !(w_ltu || w_eq);
            default: w_cmp = 1'b0;
        endcase
    end

    // multiplier partial products; only the low half of the cross terms counts
    assign w_m_lh = w_x[HALF_W-1:0] * w_y[DATA_W-1:HALF_W];
    assign w_m_hl = w_x[DATA_W-1:HALF_W] * w_y[HALF_W-1:0];

    always_comb begin
        n_exe.wide   = i_dec.wide;
        n_exe.is_mul = (i_dec.action == ACT_MUL);
        n_exe.p_ll   = w_x[HALF_W-1:0] * w_y[HALF_W-1:0];
        n_exe.p_lh   = w_m_lh[HALF_W-1:0];
        n_exe.p_hl   = w_m_hl[HALF_W-1:0];
        unique case (i_dec.action)
            ACT_ADD:    n_exe.alu = w_x + w_y;
            ACT_SUB:    n_exe.alu = w_x - w_y;
            ACT_AND:    n_exe.alu = w_x & w_y;
            ACT_OR:     n_exe.alu = w_x | w_y;
            ACT_XOR:    n_exe.alu = w_x ^ w_y;
            ACT_SHL:    n_exe.alu = w_x << w_sh;
            ACT_SHR:    n_exe.alu = w_x >> w_sh;
            ACT_SAR:    n_exe.alu = $unsigned($signed(w_sx) >>> w_sh);
            ACT_ROTR:   n_exe.alu = i_dec.wide ? w_rr64[DATA_W-1:0] : w_rr32;
            ACT_ROTL:   n_exe.alu = i_dec.wide ? w_rl64[2*DATA_W-1:DATA_W]
                                               : {{HALF_W{1'b0}},
                                                  w_rl32[DATA_W-1:HALF_W]};
            ACT_NOT:    n_exe.alu = ~w_x;
            ACT_NEG:    n_exe.alu = '0 - w_x;
            ACT_ANDC:   n_exe.alu = w_x & ~w_y;
            ACT_ORC:    n_exe.alu = w_x | ~w_y;
            ACT_EQV:    n_exe.alu = ~(w_x ^ w_y);
            ACT_NAND:   n_exe.alu = ~(w_x & w_y);
            ACT_NOR:    n_exe.alu = ~(w_x | w_y);
            ACT_EXT8S:  n_exe.alu = {{(DATA_W-8){w_x[7]}}, w_x[7:0]};
            ACT_EXT16S: n_exe.alu = {{(DATA_W-16){w_x[15]}}, w_x[15:0]};
            ACT_EXT8U:  n_exe.alu = {{(DATA_W-8){1'b0}}, w_x[7:0]};
            ACT_EXT16U: n_exe.alu = {{(DATA_W-16){1'b0}}, w_x[15:0]};
            ACT_EXT32S: n_exe.alu = {{HALF_W{w_x[HALF_W-1]}}, w_x[HALF_W-1:0]};
            ACT_EXT32U: n_exe.alu = w_x & MASK_LO;
            ACT_CMP:    n_exe.alu = {{(DATA_W-1){1'b0}}, w_cmp};
            default:    n_exe.alu = '0;   // mul and unknown codes
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
        if (w_load && i_valid) begin
            r_exe <= n_exe;
        end
    end

endmodule

[src/icf_merge.sv]
// ============================================================================
// icf_merge - result stage
// Sums the multiplier partial products, picks the result, cuts it to the
// operation width and holds it in the output register.
// ============================================================================
module icf_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  icf_pkg::t_exe             i_exe,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [icf_pkg::DATA_W-1:0] o_value
);
    import icf_pkg::*;

    logic               r_valid;
    logic [DATA_W-1:0]  r_value;
    logic [DATA_W-1:0]  n_value;
    logic [DATA_W-1:0]  w_mul;
    logic [HALF_W-1:0]  w_cross;
    logic               w_load;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_value = r_value;

    // low 64 bits of the product: low*low plus the cross terms shifted up
    assign w_cross = i_exe.p_lh + i_exe.p_hl;
    assign w_mul   = i_exe.p_ll + {w_cross, {HALF_W{1'b0}}};

    always_comb begin
        n_value = i_exe.is_mul ? w_mul : i_exe.alu;
        if (!i_exe.wide) begin
            n_value = n_value & MASK_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
        if (w_load && i_valid) begin
            r_value <= n_value;
        end
    end

endmodule

[src/ir_constant_fold_alu_unit.sv]
// ============================================================================
// ir_constant_fold_alu_unit - 32/64-bit integer ALU with compare
// Three-stage pipeline: decode, execute (with split multiplier), merge.
// ============================================================================
// The unit takes one word per cycle while the output is not stalled and
// returns each result, in order, after it has passed the decode, execute and
// merge registers. Every stage is a register with its own valid bit and its
// ready is "empty or moving on", so bubbles are squeezed out while the
// output is stalled, and the input keeps taking words until all three
// stages hold one; only then does a stalled output stop the input.
// The stage split is set by the 64-bit multiply: three 32x32 partial
// products are registered in the execute stage and summed in the merge
// stage; all other operations take the same path so results never reorder.
module ir_constant_fold_alu_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // action[4:0], wide[5], x[69:6], y[133:70], cond[137:134], zero pad
    input  logic [icf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // value[63:0]
    output logic [icf_pkg::DATA_W-1:0]         o_m_axis_tdata
);
    import icf_pkg::*;

    logic  w_dec_valid;
    logic  w_dec_ready;
    t_dec  w_dec;
    logic  w_exe_valid;
    logic  w_exe_ready;
    t_exe  w_exe;

    // decode stage
    icf_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_valid (w_dec_valid),
        .i_ready (w_dec_ready),
        .o_dec   (w_dec)
    );

    // execute stage
    icf_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .o_ready (w_dec_ready),
        .i_dec   (w_dec),
        .o_valid (w_exe_valid),
        .i_ready (w_exe_ready),
        .o_exe   (w_exe)
    );

    // result stage and output register
    icf_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_exe_valid),
        .o_ready (w_exe_ready),
        .i_exe   (w_exe),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (o_m_axis_tdata)
    );

endmodule
